>>> rtl/mlfq_pkg.sv
// Shared constants, types and codes for the MLFQ scheduler with semaphores.
// No dependencies.
package mlfq_pkg;
    localparam int PROCS     = 8;
    localparam int NUM_SEMS  = 3;
    localparam int LEVELS    = 4;
    localparam int PID_W     = 3;
    localparam int LVL_W     = 2;
    localparam int CNT_W     = 4;
    localparam int SEM_W     = 2;
    localparam int QNT_W     = 4;
    localparam int SLOT_W    = 3;
    localparam int RDY_AW    = 5;
    localparam int WL_AW     = 5;
    localparam int WL_DEPTH  = 24;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_PLAIN  = 2'd1,
        MODE_WAIT   = 2'd2,
        MODE_SIGNAL = 2'd3
    } mode_t;

    localparam logic [1:0] REG_Q1 = 2'd0;
    localparam logic [1:0] REG_Q2 = 2'd1;
    localparam logic [1:0] REG_Q3 = 2'd2;
    localparam logic [1:0] REG_Q4 = 2'd3;
endpackage

>>> rtl/mlfq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/mlfq_scheduler_with_semaphores.sv
// Top level of the MLFQ scheduler with binary semaphores.
// Depends on mlfq_pkg and mlfq_ram.
//
// Usage: each input transfer on s_axis reports one cycle of the dispatched
// process (mode, semaphore, last-instruction flag) and an optional arrival.
// Exactly one result transfer follows on m_axis: the process to run next,
// its level minus one, and an idle flag.
// Ready FIFOs (4 levels x 8 slots) and semaphore wait lists (3 x 8) are
// held in synchronous RAMs with registered reads; the scheduler
// sequences reads and write-backs one access a cycle.
// A dispatch of a new process adds a read of the ready FIFO head. A
// semaphore signal with waiters adds a scan over the waiters and a shift
// of the entries behind the woken one to compact the list; the single
// wait-list port sets this. The next item is taken only after the result
// is loaded: no new item is accepted while one is still in progress.
// Reset (aresetn low, synchronous) empties all levels and wait lists,
// frees all semaphores and restores the quantum registers to 1, 2, 4, 8.
// The RAM contents need no clearing: fill counts guard every read.
// If m_axis_tready is low, the result stays; the next item may still be
// accepted, but it waits in its last step until the result register is free.
module mlfq_scheduler_with_semaphores
    import mlfq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // tdata: mode[1:0], sem_index[3:2], last_instr[4], arrive_valid[5],
    //        arrive_pid[8:6], zero fill[15:9]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    // tdata: run_valid[0], run_pid[3:1], run_level[5:4], idle[6], zero[7]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_SEM, S_SCAN_RD, S_SCAN, S_SHIFT_RD, S_SHIFT_WR,
        S_WAKE, S_ARRIVE, S_EXPIRE, S_DISP_RD, S_DISP, S_OUT
    } state_t;

    state_t state_reg;
    logic [QNT_W-1:0]  quantum_reg [LEVELS];
    logic [SLOT_W-1:0] head_reg    [LEVELS];
    logic [CNT_W-1:0]  rcount_reg  [LEVELS];
    logic [LVL_W-1:0]  plevel_reg  [PROCS];
    logic [NUM_SEMS-1:0] busy_reg;
    logic [CNT_W-1:0]  wcount_reg  [NUM_SEMS];
    logic [PID_W-1:0]  run_pid_reg;
    logic              run_valid_reg;
    logic [QNT_W-1:0]  qleft_reg;

    // Latched item.
    logic [1:0]        mode_reg;
    logic [SEM_W-1:0]  sem_reg;
    logic              last_reg, av_reg, expire_reg;
    logic [PID_W-1:0]  ap_reg;
    // Signal scan state.
    logic [CNT_W-1:0]  idx_reg, best_reg;
    logic [2:0]        bestlv_reg;
    logic [PID_W-1:0]  bestpid_reg;
    logic [7:0]        m_data_reg;
    logic              m_valid_reg;

    // RAM ports.
    logic              r_we;
    logic [RDY_AW-1:0] r_waddr, r_raddr;
    logic [PID_W-1:0]  r_wdata, r_rdata;
    logic              w_we;
    logic [WL_AW-1:0]  w_waddr, w_raddr;
    logic [PID_W-1:0]  w_wdata, w_rdata;

    mlfq_ram #(.WIDTH(PID_W), .DEPTH(LEVELS * PROCS)) u_ready (
        .aclk(aclk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(r_rdata)
    );
    mlfq_ram #(.WIDTH(PID_W), .DEPTH(WL_DEPTH)) u_wait (
        .aclk(aclk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(w_raddr), .rdata(w_rdata)
    );

    // Address helpers.
    function automatic logic [WL_AW-1:0] wl_addr(input logic [SEM_W-1:0] s,
                                                 input logic [CNT_W-1:0] i);
        logic [WL_AW-1:0] a;
        a = WL_AW'(s) * WL_AW'(PROCS) + WL_AW'(i[SLOT_W-1:0]);
        return a;
    endfunction

    function automatic logic [RDY_AW-1:0] rd_addr(input logic [LVL_W-1:0] l,
                                                  input logic [SLOT_W-1:0] p);
        return {l, p};
    endfunction

    // Highest non-empty level.
    logic             any_ready;
    logic [LVL_W-1:0] top_lv;
    always_comb begin
        any_ready = 1'b0;
        top_lv    = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (rcount_reg[l] != '0) begin
                any_ready = 1'b1;
                top_lv    = LVL_W'(l);
            end
        end
    end

    logic sem_ok;
    assign sem_ok = (32'(sem_reg) < NUM_SEMS);
    logic [SEM_W-1:0] s_ix;
    assign s_ix = sem_ok ? sem_reg : '0;

    // Push slot for a level.
    function automatic logic [SLOT_W-1:0] tail(input logic [SLOT_W-1:0] h,
                                               input logic [CNT_W-1:0] c);
        return h + c[SLOT_W-1:0];
    endfunction

    logic [LVL_W-1:0] exp_lv;
    assign exp_lv = (plevel_reg[run_pid_reg] == LVL_W'(LEVELS - 1)) ?
                    plevel_reg[run_pid_reg] : plevel_reg[run_pid_reg] + 1'b1;
    logic [LVL_W-1:0] wake_lv;
    assign wake_lv = bestlv_reg[LVL_W-1:0];

    // RAM port control from the current state.
    always_comb begin
        r_we    = 1'b0;
        r_waddr = '0;
        r_wdata = '0;
        r_raddr = rd_addr(top_lv, head_reg[top_lv]);
        w_we    = 1'b0;
        w_waddr = wl_addr(s_ix, wcount_reg[s_ix]);
        w_wdata = run_pid_reg;
        w_raddr = wl_addr(s_ix, idx_reg);
        case (state_reg)
            S_SEM: begin
                w_we = (mode_reg == MODE_WAIT) && sem_ok && busy_reg[s_ix] &&
                       (wcount_reg[s_ix] < CNT_W'(PROCS));
            end
            S_SHIFT_RD: w_raddr = wl_addr(s_ix, idx_reg + 1'b1);
            S_SHIFT_WR: begin
                w_we    = 1'b1;
                w_waddr = wl_addr(s_ix, idx_reg);
                w_wdata = w_rdata;
            end
            S_WAKE: begin
                r_we    = rcount_reg[wake_lv] < CNT_W'(PROCS);
                r_waddr = rd_addr(wake_lv,
                                  tail(head_reg[wake_lv], rcount_reg[wake_lv]));
                r_wdata = bestpid_reg;
            end
            S_ARRIVE: begin
                r_we    = av_reg && (rcount_reg[0] < CNT_W'(PROCS));
                r_waddr = rd_addr('0, tail(head_reg[0], rcount_reg[0]));
                r_wdata = ap_reg;
            end
            S_EXPIRE: begin
                r_we    = expire_reg && (rcount_reg[exp_lv] < CNT_W'(PROCS));
                r_waddr = rd_addr(exp_lv,
                                  tail(head_reg[exp_lv], rcount_reg[exp_lv]));
                r_wdata = run_pid_reg;
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Sequencer, state and registered result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            quantum_reg[0] <= 4'd1;
            quantum_reg[1] <= 4'd2;
            quantum_reg[2] <= 4'd4;
            quantum_reg[3] <= 4'd8;
            for (int l = 0; l < LEVELS; l++) begin
                head_reg[l]   <= '0;
                rcount_reg[l] <= '0;
            end
            for (int p = 0; p < PROCS; p++) plevel_reg[p] <= '0;
            for (int s = 0; s < NUM_SEMS; s++) wcount_reg[s] <= '0;
            busy_reg      <= '0;
            run_pid_reg   <= '0;
            run_valid_reg <= 1'b0;
            qleft_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_Q1:  quantum_reg[0] <= cfg_data;
                    REG_Q2:  quantum_reg[1] <= cfg_data;
                    REG_Q3:  quantum_reg[2] <= cfg_data;
                    REG_Q4:  quantum_reg[3] <= cfg_data;
                    default: ;
                endcase
            end
            // A taken result frees the register unless a new one is loaded.
            if (m_valid_reg && m_axis_tready && state_reg != S_OUT)
                m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        mode_reg   <= s_axis_tdata[1:0];
                        sem_reg    <= s_axis_tdata[3:2];
                        last_reg   <= s_axis_tdata[4];
                        av_reg     <= s_axis_tdata[5];
                        ap_reg     <= s_axis_tdata[8:6];
                        expire_reg <= 1'b0;
                        state_reg  <= S_SEM;
                    end
                end
                S_SEM: begin
                    if (run_valid_reg && mode_reg != MODE_NONE) begin
                        logic gone;
                        gone = last_reg;
                        if (mode_reg == MODE_WAIT && sem_ok) begin
                            if (busy_reg[s_ix]) begin
                                gone = 1'b1;
                                if (wcount_reg[s_ix] < CNT_W'(PROCS))
                                    wcount_reg[s_ix] <= wcount_reg[s_ix] + 1'b1;
                            end else begin
                                busy_reg[s_ix] <= 1'b1;
                            end
                        end
                        if (!gone) begin
                            qleft_reg <= qleft_reg - 1'b1;
                            if (qleft_reg == 4'd1) begin
                                gone = 1'b1;
                                expire_reg <= 1'b1;
                            end
                        end
                        if (gone) run_valid_reg <= 1'b0;
                        if (mode_reg == MODE_SIGNAL && sem_ok) begin
                            if (wcount_reg[s_ix] == '0) begin
                                busy_reg[s_ix] <= 1'b0;
                                state_reg <= S_ARRIVE;
                            end else begin
                                idx_reg    <= '0;
                                bestlv_reg <= 3'(LEVELS);
                                best_reg   <= '0;
                                state_reg  <= S_SCAN_RD;
                            end
                        end else begin
                            state_reg <= S_ARRIVE;
                        end
                    end else begin
                        state_reg <= S_ARRIVE;
                    end
                end
                // Read each waiter in turn (S_SCAN_RD, then S_SCAN); keep the lowest level.
                S_SCAN_RD: state_reg <= S_SCAN;
                S_SCAN: begin
                    if ({1'b0, plevel_reg[w_rdata]} < bestlv_reg) begin
                        bestlv_reg  <= {1'b0, plevel_reg[w_rdata]};
                        best_reg    <= idx_reg;
                        bestpid_reg <= w_rdata;
                    end
                    if (idx_reg + 1'b1 >= wcount_reg[s_ix]) begin
                        state_reg <= S_SHIFT_RD;
                        idx_reg   <= ({1'b0, plevel_reg[w_rdata]} < bestlv_reg) ?
                                     idx_reg : best_reg;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SCAN_RD;
                    end
                end
                // Compact the list over the woken entry.
                S_SHIFT_RD: begin
                    if (idx_reg + 1'b1 >= wcount_reg[s_ix]) begin
                        state_reg <= S_WAKE;
                    end else begin
                        state_reg <= S_SHIFT_WR;
                    end
                end
                S_SHIFT_WR: begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_SHIFT_RD;
                end
                S_WAKE: begin
                    wcount_reg[s_ix] <= wcount_reg[s_ix] - 1'b1;
                    busy_reg[s_ix]   <= 1'b1;
                    if (rcount_reg[wake_lv] < CNT_W'(PROCS))
                        rcount_reg[wake_lv] <= rcount_reg[wake_lv] + 1'b1;
                    state_reg <= S_ARRIVE;
                end
                S_ARRIVE: begin
                    if (av_reg) begin
                        plevel_reg[ap_reg] <= '0;
                        if (rcount_reg[0] < CNT_W'(PROCS))
                            rcount_reg[0] <= rcount_reg[0] + 1'b1;
                    end
                    state_reg <= S_EXPIRE;
                end
                // The expired process counts as ready for this dispatch.
                S_EXPIRE: begin
                    if (expire_reg) begin
                        plevel_reg[run_pid_reg] <= exp_lv;
                        if (rcount_reg[exp_lv] < CNT_W'(PROCS))
                            rcount_reg[exp_lv] <= rcount_reg[exp_lv] + 1'b1;
                    end
                    state_reg <= (!run_valid_reg && (any_ready || expire_reg)) ?
                                 S_DISP_RD : S_OUT;
                end
                S_DISP_RD: state_reg <= S_DISP;
                S_DISP: begin
                    run_pid_reg        <= r_rdata;
                    run_valid_reg      <= 1'b1;
                    plevel_reg[r_rdata] <= top_lv;
                    qleft_reg          <= (quantum_reg[top_lv] != '0) ?
                                          quantum_reg[top_lv] : 4'd1;
                    head_reg[top_lv]   <= head_reg[top_lv] + 1'b1;
                    rcount_reg[top_lv] <= rcount_reg[top_lv] - 1'b1;
                    state_reg          <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid_reg || m_axis_tready) begin
                        m_valid_reg <= 1'b1;
                        if (run_valid_reg) begin
                            m_data_reg <= {1'b0, 1'b0, plevel_reg[run_pid_reg],
                                           run_pid_reg, 1'b1};
                        end else begin
                            m_data_reg <= 8'b0100_0000;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
